// ----- rtl/core/lru_frame_replacer_assert.svh -----
`ifndef LRU_FRAME_REPLACER_ASSERT_SVH
`define LRU_FRAME_REPLACER_ASSERT_SVH

// Invariant checked at every rising clock edge outside reset.
`define LFR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequence checked in the cycle after the trigger.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lfr_pkg.sv -----
package lfr_pkg;

    localparam int FRAME_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int ACTION_W = 2;

    typedef logic [FRAME_W-1:0]  t_frame;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_VICTIM = 2'd0;
    localparam t_action ACT_PIN    = 2'd1;
    localparam t_action ACT_UNPIN  = 2'd2;

    localparam t_count CAP_RESET = 7'd64;

    // Contents handed between neighboring cells.
    typedef struct packed {
        logic   valid;
        t_frame slot;
    } t_cell_data;

    // Broadcast to every cell.
    typedef struct packed {
        logic   shift_in;
        t_frame frame;
    } t_cell_ctrl;

    // Per-cell status back to the row controller.
    typedef struct packed {
        logic hit;
        logic last;
    } t_cell_stat;

endpackage

// ----- rtl/core/lfr_cell.sv -----
module lfr_cell import lfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_cap_ok,
    input  logic       i_take_right,
    input  t_cell_data i_left,
    input  t_cell_data i_right,
    output t_cell_data o_data,
    output t_cell_stat o_stat
);

    logic   r_valid;
    t_frame r_slot;
    logic   n_valid;
    t_frame n_slot;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        if (i_ctrl.shift_in) begin
            // insert at front: take left neighbor, drop past capacity
            n_valid = i_left.valid & i_cap_ok;
            n_slot  = i_left.slot;
        end else if (i_take_right) begin
            // close the gap toward the front
            n_valid = i_right.valid;
            n_slot  = i_right.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_data.valid = r_valid;
    assign o_data.slot  = r_slot;
    assign o_stat.hit   = r_valid && (r_slot == i_ctrl.frame);
    assign o_stat.last  = r_valid && !i_right.valid;

endmodule

// ----- rtl/core/lru_frame_replacer.sv -----
// A result is valid the cycle after its transaction is accepted. One transaction
// per cycle unless a result stalls; each action finishes in one pass of the
// cell row (parallel compare, one-cell shift, victim select over all cells).
// Reset (synchronous, active low): list emptied (all cell valid bits and the
// count cleared), capacity back to 64, no result pending.
`include "lru_frame_replacer_assert.svh"

module lru_frame_replacer import lfr_pkg::*; #(
    parameter int MAX_FRAMES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    // configuration: capacity register
    input  logic    i_cfg_we,
    input  t_count  i_cfg_data,
    // request channel
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_action i_action,
    input  t_frame  i_frame,
    // result channel
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_found,
    output t_frame  o_victim_frame,
    output t_count  o_count
);

    // List state lives in a row of cells: position 0 is the newest frame,
    // valid positions always form a prefix of length r_count.

    t_count r_capacity;
    t_count r_count;
    t_count n_count;
    logic   r_out_valid;
    logic   r_found;
    t_frame r_victim_frame;

    logic   w_accept;
    logic   w_any_hit;
    t_count w_cap_eff;
    t_frame w_victim;

    t_cell_ctrl w_ctrl;
    t_cell_data w_head;
    t_cell_data w_data [MAX_FRAMES];
    t_cell_stat w_stat [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_hit;
    logic [MAX_FRAMES-1:0] w_valid;
    logic [MAX_FRAMES-1:0] w_cap_ok;
    logic [MAX_FRAMES-1:0] w_take;

    // Output register parts the channels: a new transaction is taken
    // whenever the pending result is empty or leaving this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Effective capacity: zero acts as one, clamp to the row length.
    always_comb begin
        w_cap_eff = r_capacity;
        if (r_capacity == '0) begin
            w_cap_eff = 7'd1;
        end
        if (32'(r_capacity) > MAX_FRAMES) begin
            w_cap_eff = COUNT_W'(MAX_FRAMES);
        end
    end

    assign w_any_hit = |w_hit;

    // Only an unpin of an absent frame shifts the row toward the back.
    assign w_ctrl.shift_in = w_accept && (i_action == ACT_UNPIN) && !w_any_hit;
    assign w_ctrl.frame    = i_frame;

    assign w_head.valid = 1'b1;
    assign w_head.slot  = i_frame;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
            t_cell_data w_left;
            t_cell_data w_right;

            if (gi == 0) begin : g_first
                assign w_left = w_head;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end

            if (gi == MAX_FRAMES-1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end

            assign w_hit[gi]    = w_stat[gi].hit;
            assign w_valid[gi]  = w_data[gi].valid;
            assign w_cap_ok[gi] = (32'(gi) < 32'(w_cap_eff));

            // Victim: only the oldest cell pulls from behind (an empty slot).
            // Pin: the matching cell and all behind it pull one step forward.
            assign w_take[gi] = w_accept &&
                ((i_action == ACT_VICTIM && w_stat[gi].last) ||
                 (i_action == ACT_PIN && (|w_hit[gi:0])));

            lfr_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_cap_ok     (w_cap_ok[gi]),
                .i_take_right (w_take[gi]),
                .i_left       (w_left),
                .i_right      (w_right),
                .o_data       (w_data[gi]),
                .o_stat       (w_stat[gi])
            );
        end
    endgenerate

    // Oldest frame: the one cell flagged last drives the select.
    always_comb begin
        w_victim = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (w_stat[i].last) begin
                w_victim = w_victim | w_data[i].slot;
            end
        end
    end

    // Count after the action.
    always_comb begin
        n_count = r_count;
        unique case (i_action)
            ACT_VICTIM: begin
                if (r_count != '0) begin
                    n_count = r_count - 7'd1;
                end
            end
            ACT_PIN: begin
                if (w_any_hit) begin
                    n_count = r_count - 7'd1;
                end
            end
            ACT_UNPIN: begin
                if (!w_any_hit) begin
                    // full list: oldest entries drop so the result is capacity
                    n_count = (r_count >= w_cap_eff) ? w_cap_eff : r_count + 7'd1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; count is read straight from r_count, which only moves
    // when a new result replaces the pending one.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found        <= (i_action == ACT_VICTIM) && (r_count != '0);
            r_victim_frame <= (i_action == ACT_VICTIM) ? w_victim : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_victim_frame = r_victim_frame;
    assign o_count        = r_count;

    `LFR_ASSERT_ALWAYS(a_hit_unique, i_clk, i_rst_n, $onehot0(w_hit),
        "frame listed in more than one cell")
    `LFR_ASSERT_ALWAYS(a_prefix_count, i_clk, i_rst_n,
        $countones(w_valid) == 32'(r_count),
        "cell valid bits disagree with count")
    `LFR_ASSERT_NEXT(a_victim_found, i_clk, i_rst_n,
        w_accept && i_action == ACT_VICTIM && r_count != '0,
        o_out_valid && o_found,
        "victim on nonempty list not reported")
    `LFR_ASSERT_NEXT(a_pin_shrinks, i_clk, i_rst_n,
        w_accept && i_action == ACT_PIN && w_any_hit,
        r_count == $past(r_count) - 7'd1,
        "pin of listed frame did not remove it")

endmodule

// ----- dv/lru_list_sb_pkg.sv -----
`timescale 1ns / 100ps
package lru_list_sb_pkg;
    import lfr_pkg::*;

    localparam int LIST_MAX = 64;

    typedef struct {
        logic   found;
        t_frame victim;
        t_count count;
    } t_lru_result;

    class lru_list_scoreboard;
        t_frame      listed[$];          // newest at index 0, oldest at the back
        t_count      capacity;
        t_lru_result pending_results[$];
        int          errors;

        function new();
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(t_count value);
            capacity = value;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function int position_of(t_frame f);
            foreach (listed[i]) begin
                if (listed[i] == f) return i;
            end
            return -1;
        endfunction

        function t_frame pick_listed();
            if (listed.size() == 0) return t_frame'($urandom_range(LIST_MAX - 1));
            return listed[$urandom_range(listed.size() - 1)];
        endfunction

        function t_frame pick_absent();
            t_frame f;
            f = t_frame'($urandom_range(LIST_MAX - 1));
            if (listed.size() >= LIST_MAX) return f;
            while (position_of(f) >= 0) f = t_frame'($urandom_range(LIST_MAX - 1));
            return f;
        endfunction

        // Apply one accepted transaction to the list and queue its result.
        function void note_request(t_action act, t_frame f);
            t_lru_result r;
            int pos;
            int lim;
            r.found  = 1'b0;
            r.victim = '0;
            case (act)
                ACT_VICTIM: begin
                    if (listed.size() > 0) begin
                        r.found  = 1'b1;
                        r.victim = listed[listed.size() - 1];
                        listed.delete(listed.size() - 1);
                    end
                end
                ACT_PIN: begin
                    pos = position_of(f);
                    if (pos >= 0) listed.delete(pos);
                end
                ACT_UNPIN: begin
                    if (position_of(f) < 0) begin
                        lim = (capacity == 0) ? 1 :
                              (capacity > LIST_MAX) ? LIST_MAX : int'(capacity);
                        while (listed.size() >= lim) listed.delete(listed.size() - 1);
                        listed.insert(0, f);
                    end
                end
                default: ;
            endcase
            r.count = t_count'(listed.size());
            pending_results.push_back(r);
        endfunction

        function void report_field(string name, logic [6:0] exp_v, logic [6:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic found, t_frame victim, t_count count);
            t_lru_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: extra result, expected none, actual %0d/%0d/%0d",
                         $time, found, victim, count);
                errors++;
                return;
            end
            e = pending_results[0];
            pending_results.delete(0);
            report_field("found", 7'(e.found), 7'(found));
            report_field("victim_frame", 7'(e.victim), 7'(victim));
            report_field("count", e.count, count);
        endfunction
    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import lfr_pkg::*;
    import lru_list_sb_pkg::*;

    // Action code three has no meaning in the block: no change, empty result.
    localparam t_action ACT_RSVD = 2'd3;
    localparam int      IDLE_PCT = 31;

    logic    i_clk          = 1'b0;
    logic    i_rst_n        = 1'b0;
    logic    i_cfg_we       = 1'b0;
    t_count  i_cfg_data     = '0;
    logic    i_in_valid     = 1'b0;
    t_action i_action       = ACT_VICTIM;
    t_frame  i_frame        = '0;
    logic    i_out_ready    = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    logic    o_found;
    t_frame  o_victim_frame;
    t_count  o_count;

    // Cleared for one stretch so both sides run back to back.
    bit gaps_on = 1'b1;

    lru_list_scoreboard lru_sb = new();

    lru_frame_replacer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_frame        (i_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_count        (o_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side backpressure, independent of o_out_valid.
    always @(posedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: everything sampled here holds its pre-edge value, since all
    // inputs change by NBA at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) lru_sb.set_capacity(i_cfg_data);
            if (i_in_valid && o_in_ready) lru_sb.note_request(i_action, i_frame);
            if (o_out_valid && i_out_ready)
                lru_sb.check_result(o_found, o_victim_frame, o_count);
        end
    end

    // One request transaction; valid stays up on return so a following
    // transaction can go back to back.
    task automatic send_item(t_action act, t_frame f);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_frame    <= f;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender holds off until every queued result has been checked.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (lru_sb.pending_count() != 0);
    endtask

    // Capacity writes happen only with the pipe empty.
    task automatic write_capacity(t_count value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random mix: unpin mostly of absent frames (some of listed ones), pin
    // mostly of listed frames, the rest victims plus a few reserved codes.
    task automatic run_phase(t_count cap, int unpin_pct, int n_items);
        int      r;
        t_action act;
        t_frame  f;
        write_capacity(cap);
        repeat (n_items) begin
            r = $urandom_range(99);
            f = t_frame'($urandom_range(63));
            if (r >= 97) begin
                act = ACT_RSVD;
            end else if (r < unpin_pct) begin
                act = ACT_UNPIN;
                f   = ($urandom_range(3) == 0) ? lru_sb.pick_listed() : lru_sb.pick_absent();
            end else if (r < unpin_pct + (97 - unpin_pct) / 2) begin
                act = ACT_PIN;
                if ($urandom_range(3) != 0) f = lru_sb.pick_listed();
            end else begin
                act = ACT_VICTIM;
            end
            send_item(act, f);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, absent pin, repeat unpin, reserved code,
        // removal at front, middle and back, frames 0 and 63.
        send_item(ACT_VICTIM, 6'd17);   // empty victim
        send_item(ACT_PIN,    6'd5);    // pin of absent frame
        send_item(ACT_UNPIN,  6'd0);
        send_item(ACT_UNPIN,  6'd63);
        send_item(ACT_UNPIN,  6'd0);    // already listed, position kept
        send_item(ACT_RSVD,   6'd63);
        send_item(ACT_PIN,    6'd0);    // oldest position
        send_item(ACT_UNPIN,  6'd21);
        send_item(ACT_UNPIN,  6'd42);
        send_item(ACT_PIN,    6'd21);   // middle position
        send_item(ACT_VICTIM, 6'd63);
        send_item(ACT_VICTIM, 6'd0);
        send_item(ACT_VICTIM, 6'd0);    // empty again

        // Capacity zero acts as one.
        write_capacity(7'd0);
        send_item(ACT_UNPIN,  6'd1);
        send_item(ACT_UNPIN,  6'd2);    // drops frame 1
        send_item(ACT_UNPIN,  6'd2);
        send_item(ACT_VICTIM, 6'd0);

        // Lower capacity under the count: next new unpin drops several.
        write_capacity(7'd2);
        send_item(ACT_UNPIN,  6'd7);
        send_item(ACT_UNPIN,  6'd8);
        send_item(ACT_UNPIN,  6'd9);
        write_capacity(7'd1);
        send_item(ACT_UNPIN,  6'd10);
        send_item(ACT_VICTIM, 6'd0);

        // Random phases: fill to 64, then shrink below count, then settings
        // above the limit, the minimum, zero, a random one and 64 again.
        run_phase(7'd64, 92, 80);
        run_phase(7'd3, 50, 60);
        run_phase(7'd127, 60, 80);
        gaps_on <= 1'b0;
        run_phase(7'd65, 70, 80);
        gaps_on <= 1'b1;
        run_phase(7'd1, 40, 50);
        run_phase(7'd0, 40, 50);
        run_phase(t_count'($urandom_range(2, 63)), 50, 100);
        run_phase(7'd64, 55, 100);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (lru_sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
